// ===== hdl/rsst_pkg.sv =====
// ----------------------------------------------------------------------------
// rsst_pkg: shared types and constants for the range-sum segment tree
// Field widths, item kind codes and the sequencer state type.
// ----------------------------------------------------------------------------
package rsst_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 10;
  localparam int CNT_W  = 11;

  // Item kind codes
  localparam logic KIND_SET = 1'b0;
  localparam logic KIND_SUM = 1'b1;

  typedef logic [DATA_W-1:0] data_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET_RD,
    ST_SET_UPD,
    ST_SUM_L,
    ST_SUM_R,
    ST_SUM_OUT
  } state_t;

endpackage

// ===== hdl/rsst_node_mem.sv =====
// ----------------------------------------------------------------------------
// rsst_node_mem: node sum storage
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rsst_node_mem #(
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = 11
) (
  input  logic                clk,
  input  logic                we,
  input  logic [ADDR_W-1:0]   waddr,
  input  rsst_pkg::data_t     wdata,
  input  logic                re,
  input  logic [ADDR_W-1:0]   raddr,
  output rsst_pkg::data_t     rdata
);

  rsst_pkg::data_t mem [DEPTH];
  rsst_pkg::data_t rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/rsst_addsub.sv =====
// ----------------------------------------------------------------------------
// rsst_addsub: shared 32-bit adder/subtractor
// Computes a + b or a - b, wrapping modulo 2^32.
// ----------------------------------------------------------------------------
module rsst_addsub (
  input  rsst_pkg::data_t a,
  input  rsst_pkg::data_t b,
  input  logic            sub,
  output rsst_pkg::data_t y
);

  rsst_pkg::data_t b_inv;

  // Invert b and carry in one for subtraction
  assign b_inv = sub ? ~b : b;
  assign y     = a + b_inv + rsst_pkg::data_t'(sub);

endmodule

// ===== hdl/range_sum_segment_tree_unit.sv =====
// A set walks leaf to root through ST_SET_RD and then ST_SET_UPD at one node per cycle,
// writing each node and reading its parent; a sum alternates ST_SUM_L and ST_SUM_R once per
// tree level, then ST_SUM_OUT registers the result and strobes out_valid.
// Throughput: one item at a time; busy stays high until the item is finished.
// Reset: rst_n clears control and starts a clearing pass that writes zero to every node
// memory entry while busy is high; results are strobed and the receiver cannot stall.
// ----------------------------------------------------------------------------
// range_sum_segment_tree_unit: segment tree with point set and range sum
// Sequencer driving one node memory and one shared adder/subtractor.
// ----------------------------------------------------------------------------
module range_sum_segment_tree_unit #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_kind,
  input  logic [rsst_pkg::IDX_W-1:0]    in_index,
  input  logic [rsst_pkg::IDX_W-1:0]    in_right_index,
  input  logic signed [rsst_pkg::DATA_W-1:0] in_value,
  output logic                          out_valid,
  output logic signed [rsst_pkg::DATA_W-1:0] out_range_sum,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rsst_pkg::CNT_W-1:0]    cfg_element_count
);

  localparam int DEPTH = 2 * MAX_ELEMENTS;
  localparam int NW    = $clog2(DEPTH);
  localparam int SW    = NW + 1;
  localparam int CW    = rsst_pkg::CNT_W;

  rsst_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]   count_r;
  logic [NW-1:0]   node_r, node_nxt;
  logic [SW-1:0]   l_r, l_nxt, r_r, r_nxt;
  logic            leaf_r, leaf_nxt;
  logic            pend_r, pend_nxt;
  rsst_pkg::data_t value_r, value_nxt;
  rsst_pkg::data_t delta_r, delta_nxt;
  rsst_pkg::data_t acc_r, acc_nxt;
  logic            out_valid_r, out_valid_nxt;
  rsst_pkg::data_t out_sum_r, out_sum_nxt;

  logic            mem_we, mem_re;
  logic [NW-1:0]   mem_waddr, mem_raddr;
  rsst_pkg::data_t mem_wdata, mem_rdata;

  rsst_pkg::data_t alu_a, alu_b, alu_y;
  logic            alu_sub;

  logic            accept;
  logic [CW-1:0]   cnt_m1;
  logic [CW-1:0]   right_clip;
  logic            empty;

  // Configuration: count saturated at MAX_ELEMENTS
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      if (DEPTH / 2 > 1024) begin
        count_r <= CW'(1024);
      end else begin
        count_r <= CW'(MAX_ELEMENTS);
      end
    end else if (cfg_valid && cfg_ready) begin
      if (32'(cfg_element_count) > 32'(MAX_ELEMENTS)) begin
        count_r <= CW'(MAX_ELEMENTS);
      end else begin
        count_r <= cfg_element_count;
      end
    end
  end

  // Input transfer and range clipping
  assign busy       = (state_r != rsst_pkg::ST_IDLE);
  assign accept     = start && !busy;
  assign cnt_m1     = count_r - CW'(1);
  assign right_clip = (CW'(in_right_index) > cnt_m1) ? cnt_m1 : CW'(in_right_index);
  assign empty      = (count_r == '0) || (CW'(in_index) > right_clip);

  // Shared adder operand selection
  always_comb begin
    alu_a   = acc_r;
    alu_b   = mem_rdata;
    alu_sub = 1'b0;
    if (state_r == rsst_pkg::ST_SET_UPD) begin
      if (leaf_r) begin
        alu_a   = value_r;
        alu_b   = mem_rdata;
        alu_sub = 1'b1;
      end else begin
        alu_a   = mem_rdata;
        alu_b   = delta_r;
      end
    end
  end

  rsst_addsub u_addsub (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .y   (alu_y)
  );

  rsst_node_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (NW)
  ) u_node_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Sequencer: next state, memory controls, datapath updates
  always_comb begin
    state_nxt     = state_r;
    node_nxt      = node_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    leaf_nxt      = leaf_r;
    pend_nxt      = 1'b0;
    value_nxt     = value_r;
    delta_nxt     = delta_r;
    acc_nxt       = acc_r;
    out_valid_nxt = 1'b0;
    out_sum_nxt   = out_sum_r;
    mem_we        = 1'b0;
    mem_waddr     = node_r;
    mem_wdata     = alu_y;
    mem_re        = 1'b0;
    mem_raddr     = node_r;

    // Fold in read data issued last cycle
    if (pend_r) begin
      acc_nxt = alu_y;
    end

    case (state_r)
      rsst_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = node_r;
        mem_wdata = '0;
        node_nxt  = node_r + NW'(1);
        if (node_r == NW'(DEPTH - 1)) begin
          state_nxt = rsst_pkg::ST_IDLE;
        end
      end
      rsst_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_kind == rsst_pkg::KIND_SET) begin
            // Drop sets beyond the count
            if (CW'(in_index) < count_r) begin
              node_nxt  = NW'(MAX_ELEMENTS) + NW'(in_index);
              value_nxt = rsst_pkg::data_t'(in_value);
              state_nxt = rsst_pkg::ST_SET_RD;
            end
          end else begin
            acc_nxt = '0;
            if (empty) begin
              l_nxt = '0;
              r_nxt = '0;
            end else begin
              l_nxt = SW'(MAX_ELEMENTS) + SW'(in_index);
              r_nxt = SW'(MAX_ELEMENTS) + SW'(right_clip) + SW'(1);
            end
            state_nxt = rsst_pkg::ST_SUM_L;
          end
        end
      end
      rsst_pkg::ST_SET_RD: begin
        mem_re    = 1'b1;
        mem_raddr = node_r;
        leaf_nxt  = 1'b1;
        state_nxt = rsst_pkg::ST_SET_UPD;
      end
      rsst_pkg::ST_SET_UPD: begin
        // Write this node, read its parent unless this is the root
        mem_we    = 1'b1;
        mem_waddr = node_r;
        mem_wdata = leaf_r ? value_r : alu_y;
        if (leaf_r) begin
          delta_nxt = alu_y;
        end
        leaf_nxt = 1'b0;
        if (node_r == NW'(1)) begin
          state_nxt = rsst_pkg::ST_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = node_r >> 1;
          node_nxt  = node_r >> 1;
        end
      end
      rsst_pkg::ST_SUM_L: begin
        if (l_r < r_r) begin
          if (l_r[0]) begin
            mem_re    = 1'b1;
            mem_raddr = NW'(l_r);
            pend_nxt  = 1'b1;
            l_nxt     = l_r + SW'(1);
          end
          state_nxt = rsst_pkg::ST_SUM_R;
        end else begin
          state_nxt = rsst_pkg::ST_SUM_OUT;
        end
      end
      rsst_pkg::ST_SUM_R: begin
        if (r_r[0]) begin
          mem_re    = 1'b1;
          mem_raddr = NW'(r_r - SW'(1));
          pend_nxt  = 1'b1;
        end
        // Advance one level up
        l_nxt     = l_r >> 1;
        r_nxt     = r_r >> 1;
        state_nxt = rsst_pkg::ST_SUM_L;
      end
      rsst_pkg::ST_SUM_OUT: begin
        out_valid_nxt = 1'b1;
        out_sum_nxt   = acc_r;
        state_nxt     = rsst_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = rsst_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rsst_pkg::ST_CLEAR;
      node_r      <= '0;
      pend_r      <= 1'b0;
      leaf_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      node_r      <= node_nxt;
      pend_r      <= pend_nxt;
      leaf_r      <= leaf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    l_r       <= l_nxt;
    r_r       <= r_nxt;
    value_r   <= value_nxt;
    delta_r   <= delta_nxt;
    acc_r     <= acc_nxt;
    out_sum_r <= out_sum_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_range_sum = out_sum_r;

endmodule
